>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/blpw_pkg.sv
// types and constants of the line pixel writer
package blpw_pkg;

	// configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_FB_BASE       = 3'd0;
	localparam cfg_idx_t CFG_SCREEN_WIDTH  = 3'd1;
	localparam cfg_idx_t CFG_SCREEN_HEIGHT = 3'd2;
	localparam cfg_idx_t CFG_ROW_PITCH     = 3'd3;
	localparam cfg_idx_t CFG_ENABLE        = 3'd4;

	// command modes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	localparam int ADDR_W  = 32;
	localparam int PITCH_W = 20;
	localparam int FIELD_W = 16;

	// command item
	typedef struct packed {
		logic               mode;
		logic [FIELD_W-1:0] start_x;
		logic [FIELD_W-1:0] start_y;
		logic [FIELD_W-1:0] end_x_in;
		logic [FIELD_W-1:0] end_y_in;
		logic [31:0]        line_color;
	} cmd_item_t;

	// pixel write item
	typedef struct packed {
		logic [ADDR_W-1:0] write_addr;
		logic [31:0]       write_data;
		logic              write_valid;
		logic              last;
	} px_item_t;

endpackage

>>> hdl/blpw_step.sv
// one bresenham step: next position and error term
module blpw_step #(
	parameter int COORD_BITS = 16
) (
	input  logic [COORD_BITS-1:0]        cur_x,
	input  logic [COORD_BITS-1:0]        cur_y,
	input  logic                         dir_x_neg,
	input  logic                         dir_y_neg,
	input  logic [COORD_BITS-1:0]        dx,
	input  logic [COORD_BITS-1:0]        dy,
	input  logic signed [COORD_BITS+1:0] err,
	output logic [COORD_BITS-1:0]        nxt_x,
	output logic [COORD_BITS-1:0]        nxt_y,
	output logic signed [COORD_BITS+1:0] nxt_err
);

	localparam int ERR_W = COORD_BITS + 2;

	logic signed [ERR_W:0] e2;
	logic signed [ERR_W:0] err_w;
	logic signed [ERR_W:0] dx_s;
	logic signed [ERR_W:0] dy_s;
	logic signed [ERR_W:0] err_sum;
	logic                  step_x;
	logic                  step_y;

	// widened operands
	assign e2    = {err, 1'b0};
	assign err_w = {err[ERR_W-1], err};
	assign dx_s  = (ERR_W+1)'(dx);
	assign dy_s  = (ERR_W+1)'(dy);

	// step decisions from doubled error
	assign step_x = e2 > -dy_s;
	assign step_y = e2 < dx_s;

	// error update
	assign err_sum = err_w - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
	assign nxt_err = err_sum[ERR_W-1:0];

	// coordinate update, wraps at the coordinate width
	always_comb begin
		nxt_x = cur_x;
		nxt_y = cur_y;
		if (step_x) begin
			nxt_x = dir_x_neg ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
		end
		if (step_y) begin
			nxt_y = dir_y_neg ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
		end
	end

endmodule

>>> hdl/bresenham_line_pixel_writer.sv
// top level of the bresenham line pixel writer
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   cmd     | in        | cmd_valid / cmd_ready | blpw_pkg::cmd_item_t
//   px      | out       | px_valid / px_ready   | blpw_pkg::px_item_t
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one command item per cycle while cmd_ready is high; a tick on an active line sends its
// pixel write through the row multiply stage, then address add into the output register
// asynchronous active-low reset clears all but payload registers; no line is left active
// cmd_ready drops only when both the multiply stage and the output register hold an item
// and px_ready is low; cfg_ready is always high
module bresenham_line_pixel_writer #(
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  blpw_pkg::cmd_item_t  cmd,
	output logic                 px_valid,
	input  logic                 px_ready,
	output blpw_pkg::px_item_t   px,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  blpw_pkg::cfg_idx_t   cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int ERR_W = COORD_BITS + 2;
	localparam int CMP_W = (COORD_BITS > blpw_pkg::FIELD_W) ? COORD_BITS : blpw_pkg::FIELD_W;

	// configuration registers
	logic [blpw_pkg::ADDR_W-1:0]  fb_base_q;
	logic [blpw_pkg::FIELD_W-1:0] scr_w_q;
	logic [blpw_pkg::FIELD_W-1:0] scr_h_q;
	logic [blpw_pkg::PITCH_W-1:0] pitch_q;
	logic                         enable_q;

	// line state
	logic [COORD_BITS-1:0]   cur_x_q;
	logic [COORD_BITS-1:0]   cur_y_q;
	logic [COORD_BITS-1:0]   tgt_x_q;
	logic [COORD_BITS-1:0]   tgt_y_q;
	logic                    dir_x_neg_q;
	logic                    dir_y_neg_q;
	logic [COORD_BITS-1:0]   dx_q;
	logic [COORD_BITS-1:0]   dy_q;
	logic signed [ERR_W-1:0] err_q;
	logic [31:0]             color_q;
	logic                    busy_q;

	// multiply stage
	logic                        s1_valid_q;
	logic [COORD_BITS-1:0]       x_s1;
	logic [blpw_pkg::ADDR_W-1:0] prod_s1;
	logic [31:0]                 color_s1;
	logic                        wv_s1;
	logic                        last_s1;

	// output register
	logic               px_valid_q;
	blpw_pkg::px_item_t px_q;

	logic                    cmd_acc;
	logic                    start;
	logic                    tick_emit;
	logic                    fin;
	logic                    adv;
	logic                    in_bounds;
	logic [COORD_BITS-1:0]   x0, y0, x1, y1;
	logic [COORD_BITS-1:0]   dx0, dy0;
	logic signed [ERR_W-1:0] err0;
	logic [COORD_BITS-1:0]   nxt_x, nxt_y;
	logic signed [ERR_W-1:0] nxt_err;
	logic [blpw_pkg::ADDR_W-1:0] row_prod;

	// handshakes
	assign cfg_ready = 1'b1;
	assign adv       = !px_valid_q || px_ready;
	assign cmd_ready = !s1_valid_q || adv;
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign start     = cmd_acc && (cmd.mode == blpw_pkg::MODE_START);
	assign tick_emit = cmd_acc && (cmd.mode == blpw_pkg::MODE_TICK) && busy_q;

	// line setup from the endpoints
	assign x0   = COORD_BITS'(cmd.start_x);
	assign y0   = COORD_BITS'(cmd.start_y);
	assign x1   = COORD_BITS'(cmd.end_x_in);
	assign y1   = COORD_BITS'(cmd.end_y_in);
	assign dx0  = (x1 > x0) ? x1 - x0 : x0 - x1;
	assign dy0  = (y1 > y0) ? y1 - y0 : y0 - y1;
	assign err0 = ERR_W'(dx0) - ERR_W'(dy0);

	// current pixel checks
	assign fin       = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
	assign in_bounds = (CMP_W'(cur_x_q) < CMP_W'(scr_w_q)) &&
	                   (CMP_W'(cur_y_q) < CMP_W'(scr_h_q));
	assign row_prod  = blpw_pkg::ADDR_W'(cur_y_q) * blpw_pkg::ADDR_W'(pitch_q);

	blpw_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.cur_x     (cur_x_q),
		.cur_y     (cur_y_q),
		.dir_x_neg (dir_x_neg_q),
		.dir_y_neg (dir_y_neg_q),
		.dx        (dx_q),
		.dy        (dy_q),
		.err       (err_q),
		.nxt_x     (nxt_x),
		.nxt_y     (nxt_y),
		.nxt_err   (nxt_err)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_base_q <= '0;
			scr_w_q   <= '0;
			scr_h_q   <= '0;
			pitch_q   <= '0;
			enable_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				blpw_pkg::CFG_FB_BASE:       fb_base_q <= cfg_data;
				blpw_pkg::CFG_SCREEN_WIDTH:  scr_w_q   <= cfg_data[blpw_pkg::FIELD_W-1:0];
				blpw_pkg::CFG_SCREEN_HEIGHT: scr_h_q   <= cfg_data[blpw_pkg::FIELD_W-1:0];
				blpw_pkg::CFG_ROW_PITCH:     pitch_q   <= cfg_data[blpw_pkg::PITCH_W-1:0];
				blpw_pkg::CFG_ENABLE:        enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// line state: load on start, advance on each emitted pixel, clear busy at the end point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			tgt_x_q     <= '0;
			tgt_y_q     <= '0;
			dir_x_neg_q <= 1'b0;
			dir_y_neg_q <= 1'b0;
			dx_q        <= '0;
			dy_q        <= '0;
			err_q       <= '0;
			color_q     <= '0;
			busy_q      <= 1'b0;
		end else if (start) begin
			cur_x_q     <= x0;
			cur_y_q     <= y0;
			tgt_x_q     <= x1;
			tgt_y_q     <= y1;
			dir_x_neg_q <= !(x0 < x1);
			dir_y_neg_q <= !(y0 < y1);
			dx_q        <= dx0;
			dy_q        <= dy0;
			err_q       <= err0;
			color_q     <= cmd.line_color;
			busy_q      <= 1'b1;
		end else if (tick_emit) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else begin
				cur_x_q <= nxt_x;
				cur_y_q <= nxt_y;
				err_q   <= nxt_err;
			end
		end
	end

	// multiply stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd_ready) begin
			s1_valid_q <= tick_emit;
		end
	end

	// multiply stage payload
	always_ff @(posedge clk) begin
		if (tick_emit) begin
			x_s1     <= cur_x_q;
			prod_s1  <= row_prod;
			color_s1 <= color_q;
			wv_s1    <= enable_q && in_bounds;
			last_s1  <= fin;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_valid_q <= 1'b0;
		end else if (adv) begin
			px_valid_q <= s1_valid_q;
		end
	end

	// output register payload: base + row offset + column bytes
	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			px_q.write_addr  <= fb_base_q + prod_s1 + blpw_pkg::ADDR_W'({x_s1, 2'b00});
			px_q.write_data  <= color_s1;
			px_q.write_valid <= wv_s1;
			px_q.last        <= last_s1;
		end
	end

	assign px_valid = px_valid_q;
	assign px       = px_q;

endmodule

>>> hdl/blpw_checker.sv
// port-level checks of the line pixel writer and their binding
`include "assert_macros.svh"

module blpw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                px_valid,
	input logic                px_ready,
	input blpw_pkg::px_item_t  px
);

	logic cmd_acc;
	assign cmd_acc = cmd_valid && cmd_ready;

	// a stalled pixel item holds
	`ASSERT_NEXT(a_px_hold, px_valid && !px_ready, px_valid && $stable(px), "px item changed while stalled")

	// commands stall only behind a stalled pixel write
	`ASSERT_SAME(a_cmd_stall, !cmd_ready, px_valid && !px_ready, "cmd stalled without output backpressure")

	// idle cycles with px_ready high drain the multiply stage and output register of pixel items
	`ASSERT_NEXT(a_drain, (!cmd_acc && px_ready) ##1 (!cmd_acc && px_ready), !px_valid, "pixel item without pending tick")

endmodule

bind bresenham_line_pixel_writer blpw_checker u_blpw_checker (.*);
